@@ sv/assert_macros.svh @@
// assertion macros for the splitter's sequencer
// expects signals named clk and rst in the including module's scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("splitter assertion failed");
`define ASSERT_CLK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("splitter assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_CLK_ALWAYS(lbl, prop)
`endif
`endif

@@ sv/dss_pkg.sv @@
// shared constants, types and helpers for the delimiter string splitter
// no dependencies
package dss_pkg;

  localparam int MAX_DELIM = 16;
  localparam int WIN_DEPTH = MAX_DELIM + 1;
  localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int DATA_W    = 64;
  localparam int LEAD_BIT  = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_HIGH = 2'd2;

  // configuration reset values
  localparam logic [LEN_W-1:0]  RST_DELIM_LEN  = 5'd1;
  localparam logic [DATA_W-1:0] RST_DELIM_LOW  = 64'd44;
  localparam logic [DATA_W-1:0] RST_DELIM_HIGH = 64'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SKIP,
    ST_FLUSH
  } dss_state_t;

  // broadcast control for the window cells
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [CNT_W-1:0] wr_idx;
    logic [CNT_W-1:0] len;
  } cell_ctrl_t;

  // clamp the raw length register to 1..MAX_DELIM
  function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [CNT_W-1:0] n;
    n = CNT_W'(raw);
    if (raw == '0) n = CNT_W'(1);
    else if (raw > LEN_W'(MAX_DELIM)) n = CNT_W'(MAX_DELIM);
    return n;
  endfunction

endpackage

@@ sv/dss_cell.sv @@
// one byte cell of the look-ahead window: load, shift toward head, compare
// depends on dss_pkg
module dss_cell import dss_pkg::*; (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic [CNT_W-1:0] idx,
  input  logic [7:0]       new_byte,
  input  logic [7:0]       next_byte,
  input  logic [7:0]       delim_byte,
  output logic [7:0]       cell_byte,
  output logic             eq
);

  // shift from the neighbor or take the incoming byte at our slot
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      cell_byte <= next_byte;
    end else if (ctrl.wr_en && (ctrl.wr_idx == idx)) begin
      cell_byte <= new_byte;
    end
  end

  // cells beyond the delimiter length always agree
  assign eq = (idx >= ctrl.len) || (cell_byte == delim_byte);

endmodule

@@ sv/dss_ctrl.sv @@
// sequencer for the splitter: config registers, window count, match and
// flush control, output register; depends on dss_pkg and assert_macros.svh
`include "assert_macros.svh"
module dss_ctrl import dss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   src_present,
  input  logic                   src_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             seg_byte,
  output logic                   seg_byte_valid,
  output logic                   seg_end,
  output logic                   string_end,
  output logic                   run_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]      cfg_data,
  input  logic [7:0]             head_byte,
  input  logic [WIN_DEPTH-1:0]   eq_vec,
  output cell_ctrl_t             cell_ctrl,
  output logic [8*MAX_DELIM-1:0] delim_bytes
);

  dss_state_t       state, state_next;
  logic [LEN_W-1:0] delim_len;
  logic [DATA_W-1:0] delim_low, delim_high;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] skip_cnt, skip_next;
  logic             trail, trail_next;
  logic             last_q, last_next;

  logic [CNT_W-1:0] len;
  logic             hit, loop_go, out_free;
  logic [CNT_W-1:0] count_after;
  logic             shift, wr_en, emit;
  logic [7:0]       e_byte;
  logic             e_valid, e_end, e_str, e_run;

  assign len         = eff_len(delim_len);
  assign hit         = &eq_vec;
  assign loop_go     = count > len;
  assign out_free    = !out_valid || out_ready;
  assign cfg_ready   = 1'b1;
  assign delim_bytes = {delim_high, delim_low};
  assign count_after = (!trail && hit) ? (count - len) : (count - CNT_W'(1));

  assign cell_ctrl.shift  = shift;
  assign cell_ctrl.wr_en  = wr_en;
  assign cell_ctrl.wr_idx = count;
  assign cell_ctrl.len    = len;

  // configuration write transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_len  <= RST_DELIM_LEN;
      delim_low  <= RST_DELIM_LOW;
      delim_high <= RST_DELIM_HIGH;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DELIM_LEN:  delim_len  <= cfg_data[LEN_W-1:0];
        CFG_DELIM_LOW:  delim_low  <= cfg_data;
        CFG_DELIM_HIGH: delim_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (loop_go) begin
          if (out_free && !trail && hit && (len > CNT_W'(1))) state_next = ST_SKIP;
        end else if (last_q) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SKIP: begin
        if (skip_cnt == CNT_W'(1)) state_next = ST_SCAN;
      end
      ST_FLUSH: begin
        if (out_free && (count <= CNT_W'(1))) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath control and result formation
  always_comb begin
    in_ready   = 1'b0;
    shift      = 1'b0;
    wr_en      = 1'b0;
    emit       = 1'b0;
    e_byte     = 8'h00;
    e_valid    = 1'b0;
    e_end      = 1'b0;
    e_str      = 1'b0;
    e_run      = 1'b0;
    count_next = count;
    trail_next = trail;
    skip_next  = skip_cnt;
    last_next  = last_q;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_next = src_last;
          if (src_present && (count < CNT_W'(WIN_DEPTH))) begin
            wr_en      = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (loop_go && out_free) begin
          emit       = 1'b1;
          shift      = 1'b1;
          count_next = count - CNT_W'(1);
          e_run      = !last_q && (count_after <= len);
          if (trail) begin
            e_byte     = head_byte;
            e_valid    = 1'b1;
            trail_next = 1'b0;
          end else if (hit) begin
            e_end     = 1'b1;
            skip_next = len - CNT_W'(1);
          end else begin
            e_byte     = head_byte;
            e_valid    = 1'b1;
            trail_next = head_byte[LEAD_BIT];
          end
        end
      end
      ST_SKIP: begin
        // drop the rest of a matched delimiter
        shift      = 1'b1;
        count_next = count - CNT_W'(1);
        skip_next  = skip_cnt - CNT_W'(1);
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit = 1'b1;
          if (count == '0) begin
            e_end      = 1'b1;
            e_str      = 1'b1;
            e_run      = 1'b1;
            trail_next = 1'b0;
          end else begin
            e_byte     = head_byte;
            e_valid    = 1'b1;
            shift      = 1'b1;
            count_next = count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              e_end      = 1'b1;
              e_str      = 1'b1;
              e_run      = 1'b1;
              trail_next = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      trail    <= 1'b0;
      last_q   <= 1'b0;
      skip_cnt <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      trail    <= trail_next;
      last_q   <= last_next;
      skip_cnt <= skip_next;
    end
  end

  // output register, valid held until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seg_byte       <= e_byte;
      seg_byte_valid <= e_valid;
      seg_end        <= e_end;
      string_end     <= e_str;
      run_last       <= e_run;
    end
  end

  // window never overfills
  `ASSERT_CLK(a_count_bound, count <= CNT_W'(WIN_DEPTH))
  // the string end leaves an empty window behind
  `ASSERT_CLK(a_flush_clears, (emit && e_str) |=> (count == '0) && !trail)
  // each skip cycle drops exactly one byte
  `ASSERT_CLK(a_skip_drains, (state == ST_SKIP) |=> count == CNT_W'($past(count) - 1))
  // a skip only runs while delimiter bytes remain in the window
  `ASSERT_CLK(a_skip_room, (state == ST_SKIP) |-> (count >= skip_cnt) && (skip_cnt != '0))

endmodule

@@ sv/delimiter_string_splitter_top.sv @@
// Each accepted byte is written into the window; the window is then scanned, and while
// it holds more bytes than the delimiter length its head is checked and a result is
// registered. A match drops the remaining delimiter bytes, a string end flushes every
// byte still held (an empty final segment still emits a result), and the receiver
// holding off stalls the emitting step. New bytes are accepted only while idle.
// Reset (rst, synchronous): window empty, delimiter length 1, delimiter ','.
module delimiter_string_splitter_top import dss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           src_byte,
  input  logic                 src_present,
  input  logic                 src_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           seg_byte,
  output logic                 seg_byte_valid,
  output logic                 seg_end,
  output logic                 string_end,
  output logic                 run_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cell_ctrl_t             cell_ctrl;
  logic [8*MAX_DELIM-1:0] delim_bytes;
  logic [7:0]             cell_bytes [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]   eq_vec;

  // sequencer
  dss_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .src_present    (src_present),
    .src_last       (src_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .seg_byte       (seg_byte),
    .seg_byte_valid (seg_byte_valid),
    .seg_end        (seg_end),
    .string_end     (string_end),
    .run_last       (run_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head_byte      (cell_bytes[0]),
    .eq_vec         (eq_vec),
    .cell_ctrl      (cell_ctrl),
    .delim_bytes    (delim_bytes)
  );

  // window cells, head at cell 0, each shifting from its upper neighbor
  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    logic [7:0] nbr_byte;
    logic [7:0] dl_byte;

    if (i == WIN_DEPTH - 1) begin : g_tail
      assign nbr_byte = 8'h00;
    end else begin : g_mid
      assign nbr_byte = cell_bytes[i+1];
    end

    if (i < MAX_DELIM) begin : g_dl
      assign dl_byte = delim_bytes[8*i +: 8];
    end else begin : g_nodl
      assign dl_byte = 8'h00;
    end

    dss_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .idx        (CNT_W'(i)),
      .new_byte   (src_byte),
      .next_byte  (nbr_byte),
      .delim_byte (dl_byte),
      .cell_byte  (cell_bytes[i]),
      .eq         (eq_vec[i])
    );
  end

endmodule
